// ===== src/gifp_pkg.sv =====
// Shared types and constants for the GIF header parser.
`timescale 1ns / 1ps

package gifp_pkg;

  localparam logic [7:0] FLAG_TABLE     = 8'h80;
  localparam logic [7:0] FLAG_INTERLACE = 8'h40;
  localparam logic [7:0] SIZE_MASK      = 8'h07;
  localparam logic [7:0] LABEL_GCE      = 8'hf9;
  localparam logic [7:0] GCE_TRANSP     = 8'h01;
  localparam logic [7:0] CHAR_TRAILER   = 8'h3b;  // ';'
  localparam logic [7:0] CHAR_EXT       = 8'h21;  // '!'
  localparam logic [7:0] CHAR_IMAGE     = 8'h2c;  // ','

  localparam logic [1:0] KIND_ENTRY  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] ERR_TABLE_END = 2'd0;
  localparam logic [1:0] ERR_TRAILER   = 2'd1;
  localparam logic [1:0] ERR_EXT_END   = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  entry_index;
    logic [23:0] colour_rgb;
    logic [15:0] screen_width;
    logic [15:0] screen_height;
    logic [8:0]  table_entries;
    logic        interlaced;
    logic        has_transparency;
    logic [7:0]  transparent_index;
    logic [7:0]  code_size;
    logic [1:0]  error_code;
  } result_t;

endpackage

// ===== src/gifp_if.sv =====
// Request channel interfaces for the GIF header parser.
`timescale 1ns / 1ps

interface gifp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       src_done;

  modport source (output valid, output byte_value, output src_done, input ready);
  modport sink   (input valid, input byte_value, input src_done, output ready);
endinterface

interface gifp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  entry_index;
  logic [23:0] colour_rgb;
  logic [15:0] screen_width;
  logic [15:0] screen_height;
  logic [8:0]  table_entries;
  logic        interlaced;
  logic        has_transparency;
  logic [7:0]  transparent_index;
  logic [7:0]  code_size;
  logic [1:0]  error_code;

  modport source (output valid, output kind, output entry_index, output colour_rgb,
                  output screen_width, output screen_height, output table_entries,
                  output interlaced, output has_transparency, output transparent_index,
                  output code_size, output error_code, input ready);
  modport sink   (input valid, input kind, input entry_index, input colour_rgb,
                  input screen_width, input screen_height, input table_entries,
                  input interlaced, input has_transparency, input transparent_index,
                  input code_size, input error_code, output ready);
endinterface

// ===== src/gif_header_parser.sv =====
// Each accepted byte waits in the input register; its result, if any, is in the result register.
// Throughput: one byte per cycle when not stalled; the parser steps on the held input byte.
// A stalled result register holds the parser and, one byte later, the input.
// Reset (rst_n low, synchronous): parser back to the signature phase, all
// counters and captured header fields cleared, both stages empty.
`timescale 1ns / 1ps

module gif_header_parser (
  input  logic        clk,
  input  logic        rst_n,
  gifp_in_if.sink     in_chan,
  gifp_out_if.source  out_chan
);

  logic              held_valid;
  logic [7:0]        held_byte;
  logic              held_end;
  logic              can_take;
  logic              step;
  logic              res_valid;
  gifp_pkg::result_t res;

  assign step = held_valid && can_take;

  gifp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .take       (step),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .held_end   (held_end)
  );

  gifp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .byte_value (held_byte),
    .src_done   (held_end),
    .res_valid  (res_valid),
    .res        (res)
  );

  gifp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .can_take  (can_take),
    .out_chan  (out_chan)
  );

endmodule

// ===== src/gifp_in_stage.sv =====
// Input register stage: holds one byte request until the parser takes it.
`timescale 1ns / 1ps

module gifp_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  gifp_in_if.sink    in_chan,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte,
  output logic       held_end
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       end_r;

  assign in_chan.ready = !valid_r || take;
  assign held_valid    = valid_r;
  assign held_byte     = byte_r;
  assign held_end      = end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      valid_r <= in_chan.valid;
    end
    if (in_chan.ready && in_chan.valid) begin
      byte_r <= in_chan.byte_value;
      end_r  <= in_chan.src_done;
    end
  end

endmodule

// ===== src/gifp_core.sv =====
// Parser state machine: one byte per step, at most one result per step.
`timescale 1ns / 1ps

module gifp_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        byte_value,
  input  logic              src_done,
  output logic              res_valid,
  output gifp_pkg::result_t res
);

  typedef enum logic [3:0] {
    PH_SIG, PH_LSD, PH_GTAB, PH_SCAN, PH_ELABEL, PH_ESIZE,
    PH_EDATA, PH_IDESC, PH_LTAB, PH_CODE, PH_HALT
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  fbc_r, fbc_nxt;
  logic [8:0]  entry_r, entry_nxt;
  logic [8:0]  tsize_r, tsize_nxt;
  logic [15:0] partial_r, partial_nxt;
  logic [7:0]  remain_r, remain_nxt;
  logic [7:0]  label_r, label_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic        tflag_r, tflag_nxt;
  logic [7:0]  tvalue_r, tvalue_nxt;
  logic        ilace_r, ilace_nxt;
  logic [9:0]  entry_inc;
  logic [4:0]  fbc_inc;
  logic [7:0]  remain_dec;

  assign entry_inc  = {1'b0, entry_r} + 10'd1;
  assign fbc_inc    = {1'b0, fbc_r} + 5'd1;
  assign remain_dec = remain_r - 8'd1;

  always_comb begin
    phase_nxt   = phase_r;
    fbc_nxt     = fbc_r;
    entry_nxt   = entry_r;
    tsize_nxt   = tsize_r;
    partial_nxt = partial_r;
    remain_nxt  = remain_r;
    label_nxt   = label_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    tflag_nxt   = tflag_r;
    tvalue_nxt  = tvalue_r;
    ilace_nxt   = ilace_r;
    res_valid   = 1'b0;
    res         = '0;

    if (step && phase_r != PH_HALT) begin
      if (src_done) begin
        if (phase_r == PH_GTAB || phase_r == PH_LTAB) begin
          res_valid      = 1'b1;
          res.kind       = gifp_pkg::KIND_ERROR;
          res.error_code = gifp_pkg::ERR_TABLE_END;
          phase_nxt      = PH_HALT;
        end else if (phase_r == PH_ELABEL || phase_r == PH_ESIZE ||
                     phase_r == PH_EDATA) begin
          res_valid      = 1'b1;
          res.kind       = gifp_pkg::KIND_ERROR;
          res.error_code = gifp_pkg::ERR_EXT_END;
          phase_nxt      = PH_HALT;
        end
      end else begin
        unique case (phase_r)
          PH_SIG: begin
            if (fbc_inc >= 5'd6) begin
              fbc_nxt   = '0;
              phase_nxt = PH_LSD;
            end else begin
              fbc_nxt = fbc_inc[3:0];
            end
          end
          PH_LSD: begin
            case (fbc_r)
              4'd0: width_nxt  = {8'h00, byte_value};
              4'd1: width_nxt  = {byte_value, width_r[7:0]};
              4'd2: height_nxt = {8'h00, byte_value};
              4'd3: height_nxt = {byte_value, height_r[7:0]};
              4'd4: begin
                tsize_nxt   = 9'(9'd2 << byte_value[2:0]);
                partial_nxt = {8'h00, byte_value & gifp_pkg::FLAG_TABLE};
              end
              default: ;
            endcase
            if (fbc_inc >= 5'd7) begin
              fbc_nxt     = '0;
              entry_nxt   = '0;
              phase_nxt   = partial_r[7] ? PH_GTAB : PH_SCAN;
              partial_nxt = '0;
            end else begin
              fbc_nxt = fbc_inc[3:0];
            end
          end
          PH_GTAB, PH_LTAB: begin
            if (fbc_r < 4'd2) begin
              partial_nxt = {partial_r[7:0], byte_value};
              fbc_nxt     = fbc_inc[3:0];
            end else begin
              res_valid       = 1'b1;
              res.kind        = gifp_pkg::KIND_ENTRY;
              res.entry_index = entry_r[7:0];
              res.colour_rgb  = {partial_r, byte_value};
              fbc_nxt         = '0;
              partial_nxt     = '0;
              if (entry_inc >= {1'b0, tsize_r}) begin
                entry_nxt = '0;
                phase_nxt = (phase_r == PH_GTAB) ? PH_SCAN : PH_CODE;
              end else begin
                entry_nxt = entry_inc[8:0];
              end
            end
          end
          PH_SCAN: begin
            if (byte_value == gifp_pkg::CHAR_TRAILER) begin
              res_valid      = 1'b1;
              res.kind       = gifp_pkg::KIND_ERROR;
              res.error_code = gifp_pkg::ERR_TRAILER;
              phase_nxt      = PH_HALT;
            end else if (byte_value == gifp_pkg::CHAR_EXT) begin
              phase_nxt = PH_ELABEL;
            end else if (byte_value == gifp_pkg::CHAR_IMAGE) begin
              fbc_nxt   = '0;
              phase_nxt = PH_IDESC;
            end
          end
          PH_ELABEL: begin
            label_nxt = byte_value;
            phase_nxt = PH_ESIZE;
          end
          PH_ESIZE: begin
            if (byte_value == 8'h00) begin
              label_nxt = '0;
              phase_nxt = PH_SCAN;
            end else begin
              remain_nxt  = byte_value;
              fbc_nxt     = '0;
              partial_nxt = '0;
              phase_nxt   = PH_EDATA;
            end
          end
          PH_EDATA: begin
            if (label_r == gifp_pkg::LABEL_GCE) begin
              if (fbc_r == 4'd0 && (byte_value & gifp_pkg::GCE_TRANSP) != 8'h00) begin
                tflag_nxt   = 1'b1;
                tvalue_nxt  = '0;
                partial_nxt = 16'd1;
              end else if (fbc_r == 4'd3 && partial_r != 16'd0) begin
                tvalue_nxt = byte_value;
              end
            end
            if (fbc_r < 4'd15) fbc_nxt = fbc_inc[3:0];
            remain_nxt = remain_dec;
            if (remain_dec == 8'h00) begin
              label_nxt   = '0;
              partial_nxt = '0;
              fbc_nxt     = '0;
              phase_nxt   = PH_ESIZE;
            end
          end
          PH_IDESC: begin
            if (fbc_inc >= 5'd9) begin
              fbc_nxt   = '0;
              ilace_nxt = (byte_value & gifp_pkg::FLAG_INTERLACE) != 8'h00;
              if ((byte_value & gifp_pkg::FLAG_TABLE) != 8'h00) begin
                tsize_nxt   = 9'(9'd2 << byte_value[2:0]);
                entry_nxt   = '0;
                partial_nxt = '0;
                phase_nxt   = PH_LTAB;
              end else begin
                phase_nxt = PH_CODE;
              end
            end else begin
              fbc_nxt = fbc_inc[3:0];
            end
          end
          PH_CODE: begin
            res_valid             = 1'b1;
            res.kind              = gifp_pkg::KIND_HEADER;
            res.screen_width      = width_r;
            res.screen_height     = height_r;
            res.table_entries     = tsize_r;
            res.interlaced        = ilace_r;
            res.has_transparency  = tflag_r;
            res.transparent_index = tvalue_r;
            res.code_size         = byte_value;
            phase_nxt             = PH_HALT;
          end
          default: phase_nxt = PH_HALT;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_SIG;
      fbc_r     <= '0;
      entry_r   <= '0;
      tsize_r   <= '0;
      partial_r <= '0;
      remain_r  <= '0;
      label_r   <= '0;
      width_r   <= '0;
      height_r  <= '0;
      tflag_r   <= 1'b0;
      tvalue_r  <= '0;
      ilace_r   <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      fbc_r     <= fbc_nxt;
      entry_r   <= entry_nxt;
      tsize_r   <= tsize_nxt;
      partial_r <= partial_nxt;
      remain_r  <= remain_nxt;
      label_r   <= label_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      tflag_r   <= tflag_nxt;
      tvalue_r  <= tvalue_nxt;
      ilace_r   <= ilace_nxt;
    end
  end

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HALT |-> !res_valid)
    else $error("result produced after parse finished");

  a_final_halts: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.kind != gifp_pkg::KIND_ENTRY |=> phase_r == PH_HALT)
    else $error("parser did not halt after header or error");

  a_entry_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_GTAB || phase_r == PH_LTAB) |-> entry_r < tsize_r)
    else $error("entry counter beyond table size");

  a_extension_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_EDATA |-> remain_r != 8'h00)
    else $error("extension data phase with no bytes left");

endmodule

// ===== src/gifp_out_stage.sv =====
// Result register: holds one result until the sink takes it.
`timescale 1ns / 1ps

module gifp_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  gifp_pkg::result_t res,
  output logic              can_take,
  gifp_out_if.source        out_chan
);

  logic              valid_r;
  gifp_pkg::result_t res_r;

  assign can_take = !valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_take) begin
      valid_r <= res_valid;
    end
    if (can_take && res_valid) begin
      res_r <= res;
    end
  end

  assign out_chan.valid             = valid_r;
  assign out_chan.kind              = res_r.kind;
  assign out_chan.entry_index       = res_r.entry_index;
  assign out_chan.colour_rgb        = res_r.colour_rgb;
  assign out_chan.screen_width      = res_r.screen_width;
  assign out_chan.screen_height     = res_r.screen_height;
  assign out_chan.table_entries     = res_r.table_entries;
  assign out_chan.interlaced        = res_r.interlaced;
  assign out_chan.has_transparency  = res_r.has_transparency;
  assign out_chan.transparent_index = res_r.transparent_index;
  assign out_chan.code_size         = res_r.code_size;
  assign out_chan.error_code        = res_r.error_code;

endmodule

// ===== dv/gif_header_parser_test.sv =====
// Self-checking testbench for gif_header_parser: GIF byte requests against a behavioral model.
`timescale 1ns / 1ps

module gif_header_parser_test;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;
  localparam int SCAN_TARGET = 1180;

  typedef enum logic [3:0] {
    SIGNATURE, SCREEN_DESC, GLOBAL_TABLE, SCAN, EXT_LABEL, EXT_SIZE, EXT_DATA,
    IMAGE_DESC, LOCAL_TABLE, CODE_SIZE, HALTED
  } parse_phase_e;

  typedef enum logic [1:0] {END_HEADER, END_TABLE_CUT, END_TRAILER, END_EXT_CUT} finish_e;

  typedef struct packed {
    logic [7:0]  value;
    logic        ends;
    logic        typed;
    logic [7:0]  idx;
    logic [23:0] rgb;
  } stim_row_t;

  logic clk;
  logic rst_n;

  gifp_in_if  in_chan ();
  gifp_out_if out_chan ();

  gif_header_parser u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // behavioral parser state
  parse_phase_e cur_phase   = SIGNATURE;
  logic [3:0]   fld_pos     = '0;
  logic [8:0]   entry_no    = '0;
  logic [8:0]   tbl_entries = '0;
  logic [15:0]  rgb_acc     = '0;
  logic [7:0]   blk_left    = '0;
  logic [7:0]   ext_id      = '0;
  logic [15:0]  scr_w       = '0;
  logic [15:0]  scr_h       = '0;
  logic         transp_on   = 1'b0;
  logic [7:0]   transp_idx  = '0;
  logic         ilace       = 1'b0;
  logic         gce_armed   = 1'b0;
  logic         gtab_on     = 1'b0;

  gifp_pkg::result_t gif_records_due [$];
  gifp_pkg::result_t seen;

  int  items_sent   = 0;
  int  failures     = 0;
  int  n_entries    = 0;
  int  n_headers    = 0;
  int  n_errors     = 0;
  int  n_ext        = 0;
  int  n_gce        = 0;
  int  quiet_cycles = 0;
  bit  calm         = 1'b0;
  bit  draining     = 1'b0;
  bit  hold_request = 1'b0;

  // signature, screen descriptor with a 256-entry global table, first entries
  stim_row_t header_script [24] = '{
    {8'h47, 1'b0, 1'b0, 8'h00, 24'h000000},
    {8'h49, 1'b0, 1'b0, 8'h00, 24'h000000},
    {8'ha5, 1'b1, 1'b0, 8'h00, 24'h000000},
    {8'h46, 1'b0, 1'b0, 8'h00, 24'h000000},
    {8'h38, 1'b0, 1'b0, 8'h00, 24'h000000},
    {8'h39, 1'b0, 1'b0, 8'h00, 24'h000000},
    {8'h61, 1'b0, 1'b0, 8'h00, 24'h000000},
    {8'hff, 1'b0, 1'b0, 8'h00, 24'h000000},
    {8'hff, 1'b0, 1'b0, 8'h00, 24'h000000},
    {8'h5a, 1'b1, 1'b0, 8'h00, 24'h000000},
    {8'h00, 1'b0, 1'b0, 8'h00, 24'h000000},
    {8'h00, 1'b0, 1'b0, 8'h00, 24'h000000},
    {8'h87, 1'b0, 1'b0, 8'h00, 24'h000000},
    {8'h00, 1'b0, 1'b0, 8'h00, 24'h000000},
    {8'h00, 1'b0, 1'b0, 8'h00, 24'h000000},
    {8'h00, 1'b0, 1'b0, 8'h00, 24'h000000},
    {8'h00, 1'b0, 1'b0, 8'h00, 24'h000000},
    {8'h00, 1'b0, 1'b1, 8'h00, 24'h000000},
    {8'hff, 1'b0, 1'b0, 8'h00, 24'h000000},
    {8'hff, 1'b0, 1'b0, 8'h00, 24'h000000},
    {8'hff, 1'b0, 1'b1, 8'h01, 24'hffffff},
    {8'h12, 1'b0, 1'b0, 8'h00, 24'h000000},
    {8'h34, 1'b0, 1'b0, 8'h00, 24'h000000},
    {8'h56, 1'b0, 1'b0, 8'h00, 24'h000000}
  };

  function automatic void report_error(inout gifp_pkg::result_t res,
                                       input logic [1:0] code);
    res.kind       = gifp_pkg::KIND_ERROR;
    res.error_code = code;
    cur_phase      = HALTED;
  endfunction

  function automatic logic parse_gif_byte(input logic [7:0] b, input logic ended,
                                          output gifp_pkg::result_t res);
    res = '0;
    if (cur_phase == HALTED) return 1'b0;
    if (ended) begin
      if (cur_phase == GLOBAL_TABLE || cur_phase == LOCAL_TABLE) begin
        report_error(res, gifp_pkg::ERR_TABLE_END);
        return 1'b1;
      end
      if (cur_phase == EXT_LABEL || cur_phase == EXT_SIZE || cur_phase == EXT_DATA) begin
        report_error(res, gifp_pkg::ERR_EXT_END);
        return 1'b1;
      end
      return 1'b0;
    end
    case (cur_phase)
      SIGNATURE: begin
        fld_pos++;
        if (fld_pos >= 4'd6) begin
          fld_pos   = '0;
          cur_phase = SCREEN_DESC;
        end
      end
      SCREEN_DESC: begin
        case (fld_pos)
          4'd0: scr_w = {8'h00, b};
          4'd1: scr_w[15:8] = b;
          4'd2: scr_h = {8'h00, b};
          4'd3: scr_h[15:8] = b;
          4'd4: begin
            tbl_entries = 9'd2 << (b & gifp_pkg::SIZE_MASK);
            gtab_on     = (b & gifp_pkg::FLAG_TABLE) != 8'h00;
          end
          default: ;
        endcase
        fld_pos++;
        if (fld_pos >= 4'd7) begin
          fld_pos   = '0;
          entry_no  = '0;
          rgb_acc   = '0;
          cur_phase = gtab_on ? GLOBAL_TABLE : SCAN;
        end
      end
      GLOBAL_TABLE, LOCAL_TABLE: begin
        if (fld_pos < 4'd2) begin
          rgb_acc = {rgb_acc[7:0], b};
          fld_pos++;
          return 1'b0;
        end
        res.kind        = gifp_pkg::KIND_ENTRY;
        res.entry_index = entry_no[7:0];
        res.colour_rgb  = {rgb_acc, b};
        fld_pos         = '0;
        rgb_acc         = '0;
        entry_no++;
        if (entry_no >= tbl_entries) begin
          entry_no  = '0;
          cur_phase = (cur_phase == GLOBAL_TABLE) ? SCAN : CODE_SIZE;
        end
        return 1'b1;
      end
      SCAN: begin
        if (b == gifp_pkg::CHAR_TRAILER) begin
          report_error(res, gifp_pkg::ERR_TRAILER);
          return 1'b1;
        end
        if (b == gifp_pkg::CHAR_EXT) cur_phase = EXT_LABEL;
        else if (b == gifp_pkg::CHAR_IMAGE) begin
          fld_pos   = '0;
          cur_phase = IMAGE_DESC;
        end
      end
      EXT_LABEL: begin
        ext_id    = b;
        cur_phase = EXT_SIZE;
      end
      EXT_SIZE: begin
        if (b == 8'h00) begin
          ext_id    = '0;
          cur_phase = SCAN;
        end else begin
          blk_left  = b;
          fld_pos   = '0;
          gce_armed = 1'b0;
          cur_phase = EXT_DATA;
        end
      end
      EXT_DATA: begin
        if (ext_id == gifp_pkg::LABEL_GCE) begin
          if (fld_pos == 4'd0 && (b & gifp_pkg::GCE_TRANSP) != 8'h00) begin
            transp_on  = 1'b1;
            transp_idx = '0;
            gce_armed  = 1'b1;
          end else if (fld_pos == 4'd3 && gce_armed) begin
            transp_idx = b;
          end
        end
        if (fld_pos < 4'd15) fld_pos++;
        blk_left--;
        if (blk_left == 8'h00) begin
          // only the first sub-block of a control extension counts
          ext_id    = '0;
          gce_armed = 1'b0;
          fld_pos   = '0;
          cur_phase = EXT_SIZE;
        end
      end
      IMAGE_DESC: begin
        fld_pos++;
        if (fld_pos >= 4'd9) begin
          fld_pos = '0;
          ilace   = (b & gifp_pkg::FLAG_INTERLACE) != 8'h00;
          if ((b & gifp_pkg::FLAG_TABLE) != 8'h00) begin
            tbl_entries = 9'd2 << (b & gifp_pkg::SIZE_MASK);
            entry_no    = '0;
            rgb_acc     = '0;
            cur_phase   = LOCAL_TABLE;
          end else begin
            cur_phase = CODE_SIZE;
          end
        end
      end
      CODE_SIZE: begin
        res.kind              = gifp_pkg::KIND_HEADER;
        res.screen_width      = scr_w;
        res.screen_height     = scr_h;
        res.table_entries     = tbl_entries;
        res.interlaced        = ilace;
        res.has_transparency  = transp_on;
        res.transparent_index = transp_idx;
        res.code_size         = b;
        cur_phase             = HALTED;
        return 1'b1;
      end
      default: cur_phase = HALTED;
    endcase
    return 1'b0;
  endfunction

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 1;
    if (r < 92) return $urandom_range(2, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic void log_failure(string what);
    failures++;
    if (failures <= 10) $display("check: %s", what);
  endfunction

  function automatic string field_diffs(gifp_pkg::result_t e, gifp_pkg::result_t g);
    string s;
    s = "";
    if (g.kind !== e.kind)
      s = {s, $sformatf(" kind %0d/%0d", e.kind, g.kind)};
    if (g.entry_index !== e.entry_index)
      s = {s, $sformatf(" entry_index %0d/%0d", e.entry_index, g.entry_index)};
    if (g.colour_rgb !== e.colour_rgb)
      s = {s, $sformatf(" colour_rgb %06h/%06h", e.colour_rgb, g.colour_rgb)};
    if (g.screen_width !== e.screen_width)
      s = {s, $sformatf(" screen_width %0d/%0d", e.screen_width, g.screen_width)};
    if (g.screen_height !== e.screen_height)
      s = {s, $sformatf(" screen_height %0d/%0d", e.screen_height, g.screen_height)};
    if (g.table_entries !== e.table_entries)
      s = {s, $sformatf(" table_entries %0d/%0d", e.table_entries, g.table_entries)};
    if (g.interlaced !== e.interlaced)
      s = {s, $sformatf(" interlaced %0b/%0b", e.interlaced, g.interlaced)};
    if (g.has_transparency !== e.has_transparency)
      s = {s, $sformatf(" has_transparency %0b/%0b", e.has_transparency,
                        g.has_transparency)};
    if (g.transparent_index !== e.transparent_index)
      s = {s, $sformatf(" transparent_index %0d/%0d", e.transparent_index,
                        g.transparent_index)};
    if (g.code_size !== e.code_size)
      s = {s, $sformatf(" code_size %0d/%0d", e.code_size, g.code_size)};
    if (g.error_code !== e.error_code)
      s = {s, $sformatf(" error_code %0d/%0d", e.error_code, g.error_code)};
    return s;
  endfunction

  // one byte request; returns at the falling edge after acceptance, valid still high
  task automatic send(input logic [7:0] value, input logic ends,
                      input logic typed = 1'b0,
                      input gifp_pkg::result_t typed_res = '0);
    gifp_pkg::result_t r;
    logic              got;
    int                gap;
    gap = (calm || $urandom_range(0, 99) >= 35) ? 0 : idle_length();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.byte_value <= value;
    in_chan.src_done   <= ends;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    got = parse_gif_byte(value, ends, r);
    if (typed) gif_records_due.push_back(typed_res);
    else if (got) gif_records_due.push_back(r);
    items_sent++;
    if (items_sent % 50 == 0) calm = ($urandom_range(0, 4) == 0);
    @(negedge clk);
  endtask

  task automatic send_extension(input logic [7:0] label, input int blocks);
    int         len;
    int         r;
    logic [7:0] d;
    n_ext++;
    if (label == gifp_pkg::LABEL_GCE) n_gce++;
    send(gifp_pkg::CHAR_EXT, 1'b0);
    send(label, 1'b0);
    for (int k = 0; k < blocks; k++) begin
      r = $urandom_range(0, 99);
      if (label == gifp_pkg::LABEL_GCE && k == 0)
        len = (r < 70) ? 4 : (r < 85) ? $urandom_range(1, 3) : $urandom_range(5, 10);
      else
        len = (r < 3) ? 255 : (r < 10) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      send(8'(len), 1'b0);
      for (int j = 0; j < len; j++) begin
        d = 8'($urandom_range(0, 255));
        if (j == 0 && label == gifp_pkg::LABEL_GCE && $urandom_range(0, 3) != 0)
          d[0] = 1'b1;
        send(d, 1'b0);
      end
    end
    send(8'h00, 1'b0);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stalls plus one long hold on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left     = 0;
    hold_left      = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else if (!draining && !calm && $urandom_range(0, 99) < 15) begin
        stall_left = idle_length() - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      seen = {out_chan.kind, out_chan.entry_index, out_chan.colour_rgb,
              out_chan.screen_width, out_chan.screen_height, out_chan.table_entries,
              out_chan.interlaced, out_chan.has_transparency, out_chan.transparent_index,
              out_chan.code_size, out_chan.error_code};
      if (gif_records_due.size() == 0) begin
        log_failure($sformatf("unexpected result %p", seen));
      end else begin
        string diffs;
        diffs = field_diffs(gif_records_due.pop_front(), seen);
        if (diffs != "") log_failure({"result mismatch (exp/got):", diffs});
      end
      if (seen.kind == gifp_pkg::KIND_ENTRY) n_entries++;
      else if (seen.kind == gifp_pkg::KIND_HEADER) n_headers++;
      else n_errors++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    gifp_pkg::result_t want;
    logic [7:0]        d;
    int                pick;
    int                tbl_bytes;
    int                stop;
    int                len;
    finish_e           finish;
    in_chan.valid      = 1'b0;
    in_chan.byte_value = '0;
    in_chan.src_done   = 1'b0;
    rst_n              = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (header_script[i]) begin
      want             = '0;
      want.kind        = gifp_pkg::KIND_ENTRY;
      want.entry_index = header_script[i].idx;
      want.colour_rgb  = header_script[i].rgb;
      send(header_script[i].value, header_script[i].ends, header_script[i].typed, want);
    end

    // rest of the global table while the result side holds off
    hold_request = 1'b1;
    repeat (253 * 3) send(8'($urandom_range(0, 255)), 1'b0);

    in_chan.valid <= 1'b0;
    do @(negedge clk); while (gif_records_due.size() != 0);

    while (items_sent < SCAN_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_extension(gifp_pkg::LABEL_GCE,
                       ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1);
      end else if (pick < 42) begin
        send_extension($urandom_range(0, 1) ? gifp_pkg::LABEL_GCE :
                       8'($urandom_range(0, 255)), 0);
      end else if (pick < 65) begin
        send_extension(8'($urandom_range(0, 255)), $urandom_range(1, 3));
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 4)) begin
          do d = 8'($urandom_range(0, 255));
          while (d == gifp_pkg::CHAR_EXT || d == gifp_pkg::CHAR_IMAGE ||
                 d == gifp_pkg::CHAR_TRAILER);
          send(d, 1'b0);
        end
      end else begin
        send(8'($urandom_range(0, 255)), 1'b1);
      end
    end

    pick   = $urandom_range(0, 9);
    finish = (pick < 6) ? END_HEADER : (pick == 6) ? END_TABLE_CUT :
             (pick == 7) ? END_TRAILER : END_EXT_CUT;
    case (finish)
      END_HEADER, END_TABLE_CUT: begin
        send(gifp_pkg::CHAR_IMAGE, 1'b0);
        for (int k = 0; k < 9; k++) begin
          if ($urandom_range(0, 7) == 0) send(8'($urandom_range(0, 255)), 1'b1);
          d = 8'($urandom_range(0, 255));
          if (k == 8) begin
            d[7]   = (finish == END_TABLE_CUT) || ($urandom_range(0, 9) < 6);
            d[2:0] = ($urandom_range(0, 9) == 0) ? 3'd7 : 3'($urandom_range(0, 3));
          end
          send(d, 1'b0);
        end
        if (d[7]) begin
          tbl_bytes = 3 * (2 << d[2:0]);
          if (finish == END_TABLE_CUT) tbl_bytes = $urandom_range(0, tbl_bytes - 1);
          repeat (tbl_bytes) send(8'($urandom_range(0, 255)), 1'b0);
        end
        if (finish == END_TABLE_CUT) begin
          send(8'($urandom_range(0, 255)), 1'b1);
        end else begin
          if ($urandom_range(0, 1)) send(8'($urandom_range(0, 255)), 1'b1);
          send(8'($urandom_range(0, 255)), 1'b0);
        end
      end
      END_TRAILER: send(gifp_pkg::CHAR_TRAILER, 1'b0);
      default: begin
        send(gifp_pkg::CHAR_EXT, 1'b0);
        stop = $urandom_range(0, 2);
        if (stop >= 1) send(8'($urandom_range(0, 255)), 1'b0);
        if (stop == 2) begin
          len = $urandom_range(2, 8);
          send(8'(len), 1'b0);
          repeat ($urandom_range(0, len - 1)) send(8'($urandom_range(0, 255)), 1'b0);
        end
        send(8'($urandom_range(0, 255)), 1'b1);
      end
    endcase

    // parser is done; these must produce nothing
    repeat (6) send(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    in_chan.valid <= 1'b0;
    draining = 1'b1;
    do @(negedge clk); while (gif_records_due.size() != 0);
    repeat (10) @(negedge clk);

    $display("summary: %0d bytes sent, %0d extensions (%0d graphic control), end by %s",
             items_sent, n_ext, n_gce, finish.name());
    $display("summary: %0d palette entries, %0d header, %0d error results, %0d failures",
             n_entries, n_headers, n_errors, failures);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
